FILE: rtl/mogc_pkg.sv
// Shared types, constants and decode helpers for the meter offset/gain calibration block.
// Used by the serial multiplier, the serial divider and the top level; depends on nothing.
`default_nettype none

package mogc_pkg;

	// Fixed-point fraction bits of slopes and source currents.
	localparam int FRAC_BITS = 16;

	// Serial divider: dividend holds a 42-bit scaled ohm numerator shifted by the fraction bits.
	localparam int DIV_W = 42 + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	// Serial multiplier: 33-bit multiplicand, 32-bit multiplier.
	localparam int MUL_XW = 33;
	localparam int MUL_YW = 32;
	localparam int PROD_W = MUL_XW + MUL_YW;
	localparam int MUL_CNT_W = $clog2(MUL_YW + 1);

	// Measurement mode codes.
	localparam logic [2:0] OP_DC_VOLT = 3'd0;
	localparam logic [2:0] OP_AC_VOLT = 3'd1;
	localparam logic [2:0] OP_DC_AMP = 3'd2;
	localparam logic [2:0] OP_AC_AMP = 3'd3;
	localparam logic [2:0] OP_TWO_WIRE = 3'd4;
	localparam logic [2:0] OP_FOUR_WIRE = 3'd5;

	// Reset values of the gain and source-current tables.
	localparam logic [63:0] SLOPE_ONE_WIDE = 64'd1 << FRAC_BITS;
	localparam logic [31:0] SLOPE_ONE = SLOPE_ONE_WIDE[31:0];
	localparam logic [63:0] SRC_CUR0_WIDE = ((64'd49784 << FRAC_BITS) + 64'd50) / 64'd100;
	localparam logic [31:0] SRC_CUR0 = SRC_CUR0_WIDE[31:0];

	// Constant multipliers: thousandths per unit, four-wire scale and the AC rectifier factor.
	localparam logic [MUL_YW-1:0] K_TWO_WIRE = 32'd1000;
	localparam logic [MUL_YW-1:0] K_FOUR_WIRE = 32'd100;
	localparam logic [MUL_YW-1:0] K_AC = 32'd5;
	localparam int AC_SHIFT = 2;

	// Saturation limits.
	localparam logic [40:0] RES_CAP = 41'h100_0000_0000;
	localparam logic [31:0] CUR_CAP = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [2:0] op;
		logic [1:0] range_index;
		logic signed [31:0] reading;
		logic [31:0] reference;
		logic arm_zero;
		logic arm_slope;
	} item_t;

	typedef struct packed {
		logic [31:0] value;
		logic zero_captured;
		logic slope_captured;
		logic store_request;
		logic divide_error;
		logic range_error;
	} result_t;

	// Status of a serial arithmetic unit.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MAG,
		ST_PLAN,
		ST_SDIV,
		ST_MST,
		ST_MUL1,
		ST_AST,
		ST_MUL2,
		ST_CDIV,
		ST_CUR,
		ST_KMUL,
		ST_RDIV,
		ST_OHM,
		ST_FIN
	} state_t;

	// Number of ranges each mode offers.
	function automatic logic [2:0] range_limit(input logic [2:0] op);
		logic [2:0] lim;
		unique case (op)
			OP_DC_VOLT: lim = 3'd3;
			OP_AC_VOLT: lim = 3'd3;
			OP_DC_AMP: lim = 3'd3;
			OP_AC_AMP: lim = 3'd2;
			OP_TWO_WIRE: lim = 3'd4;
			OP_FOUR_WIRE: lim = 3'd4;
			default: lim = 3'd0;
		endcase
		return lim;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/mogc_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on mogc_pkg for widths and the unit status type.
`default_nettype none

module mogc_mul (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [mogc_pkg::MUL_XW-1:0] x,
	input logic [mogc_pkg::MUL_YW-1:0] y,
	output logic [mogc_pkg::PROD_W-1:0] prod,
	output mogc_pkg::unit_stat_t stat
);
	import mogc_pkg::*;

	logic [MUL_XW-1:0] x_q;
	logic [MUL_XW-1:0] hi_q;
	logic [MUL_YW-1:0] lo_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [MUL_XW:0] sum;

	// Add the multiplicand when the current multiplier bit is set.
	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, x_q} : '0);

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CNT_W'(MUL_YW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Product shift register: the partial sum enters at the top, multiplier bits leave below.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			hi_q <= '0;
			lo_q <= y;
		end else if (busy_q) begin
			hi_q <= sum[MUL_XW:1];
			lo_q <= {sum[0], lo_q[MUL_YW-1:1]};
		end
	end

	assign prod = {hi_q, lo_q};
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

FILE: rtl/mogc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on mogc_pkg for widths and the unit status type.
`default_nettype none

module mogc_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [mogc_pkg::DIV_W-1:0] dividend,
	input logic [31:0] divisor,
	output logic [mogc_pkg::DIV_W-1:0] quotient,
	output mogc_pkg::unit_stat_t stat
);
	import mogc_pkg::*;

	logic [DIV_W-1:0] num_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [32:0] trial;
	logic [32:0] trial_sub;
	logic fits;

	// Bring down the next dividend bit and try the subtraction.
	assign trial = {rem_q, num_q[DIV_W-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign fits = trial >= {1'b0, dvs_q};

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend bits shift out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[31:0] : trial[31:0];
			num_q <= {num_q[DIV_W-2:0], fits};
		end
	end

	assign quotient = num_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

FILE: rtl/meter_offset_gain_calibration_unit.sv
// Top level of the meter offset/gain calibration block: tables, sequencer and result register.
// Depends on mogc_pkg, mogc_mul and mogc_div.
`default_nettype none

// Each reading is zeroed, scaled and, on request, used to capture a new zero, gain slope or
// source current for its mode and range. One item is worked on at a time; the result register
// lets the next item in while a result waits. The time per item is set by the 32-step
// shift-and-add multiplier (one multiply in DC modes, two in AC modes); a slope capture adds
// the 58-step (42 + FRAC_BITS) restoring divider. Ohm modes take one multiply and one divide,
// and a two-wire source-current capture adds another divide. An invalid mode or range skips
// the arithmetic and goes straight to the final state that loads the result register.
module meter_offset_gain_calibration_unit (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input mogc_pkg::item_t item,
	output logic result_valid,
	input logic result_stall,
	output mogc_pkg::result_t result
);
	import mogc_pkg::*;

	state_t state_q, state_d;

	// Item registers and working values.
	logic [2:0] op_q;
	logic [1:0] n_q;
	logic [31:0] rd_q;
	logic [31:0] ref_q;
	logic zc_q, sc_q, st_q, de_q, re_q;
	logic [31:0] val_q;
	logic [32:0] diff_q;
	logic neg_q;
	logic [32:0] dm_q;
	logic [31:0] slope_q;
	logic [31:0] cur_q;
	logic [42:0] s_q;
	logic pz_q, ps_q;

	// Calibration tables.
	logic [31:0] zdv_q [3];
	logic [31:0] sdv_q [3];
	logic [31:0] zav_q [3];
	logic [31:0] zda_q [3];
	logic [31:0] sda_q [3];
	logic [31:0] zaa_q [2];
	logic [31:0] zom_q [4];
	logic [31:0] scur_q [4];

	result_t res_q;
	logic res_valid_q;

	// Arithmetic unit connections.
	logic mul_start;
	logic [MUL_XW-1:0] mul_x;
	logic [MUL_YW-1:0] mul_y;
	logic [PROD_W-1:0] mul_prod;
	unit_stat_t mul_stat;
	logic div_start;
	logic [DIV_W-1:0] div_dividend;
	logic [31:0] div_divisor;
	logic [DIV_W-1:0] quo;
	unit_stat_t div_stat;

	// Derived values.
	logic item_bad;
	logic gain_cap;
	logic ohm_cap;
	logic [31:0] zsel;
	logic [31:0] slope_sel;
	logic [31:0] cur_sel;
	logic [31:0] msat;
	logic [31:0] slope_new;
	logic [31:0] cur_lim;
	logic [31:0] cur_new;
	logic [31:0] cur_mag;
	logic [31:0] v_gain;
	logic [31:0] v_ac;
	logic [40:0] qcap;
	logic [42:0] s_new;
	logic [31:0] z_clamp;
	logic [31:0] zuse;
	logic [42:0] r_ohm;
	logic [31:0] val_ohm;
	logic load_res;

	mogc_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.x(mul_x),
		.y(mul_y),
		.prod(mul_prod),
		.stat(mul_stat)
	);

	mogc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.quotient(quo),
		.stat(div_stat)
	);

	// Range check of an incoming item.
	assign item_bad = (item.op > OP_FOUR_WIRE) ||
		((item.op != OP_FOUR_WIRE) && ({1'b0, item.range_index} >= range_limit(item.op)));

	assign gain_cap = pz_q && (op_q <= OP_AC_AMP);
	assign ohm_cap = pz_q && (op_q == OP_TWO_WIRE);

	// Table reads for the current item.
	always_comb begin
		zsel = '0;
		slope_sel = '0;
		cur_sel = '0;
		unique case (op_q)
			OP_DC_VOLT: begin
				zsel = zdv_q[n_q];
				slope_sel = sdv_q[n_q];
			end
			OP_AC_VOLT: begin
				zsel = zav_q[n_q];
				slope_sel = sdv_q[n_q];
			end
			OP_DC_AMP: begin
				zsel = zda_q[n_q];
				slope_sel = sda_q[n_q];
			end
			OP_AC_AMP: begin
				zsel = zaa_q[n_q[0]];
				slope_sel = sda_q[n_q + 2'd1];
			end
			OP_TWO_WIRE: begin
				zsel = zdv_q[2];
				cur_sel = scur_q[n_q];
			end
			default: begin
				cur_sel = scur_q[0];
			end
		endcase
	end

	// Saturations and sign handling around the arithmetic units.
	assign msat = dm_q[32] ? '1 : dm_q[31:0];
	assign slope_new = (|quo[DIV_W-1:32]) ? '1 : quo[31:0];
	assign cur_lim = (|quo[DIV_W-1:31]) ? CUR_CAP : {1'b0, quo[30:0]};
	assign cur_new = neg_q ? (~cur_lim + 32'd1) : cur_lim;
	assign cur_mag = cur_q[31] ? (~cur_q + 32'd1) : cur_q;
	assign v_gain = (|mul_prod[PROD_W-1:FRAC_BITS+32]) ? '1 : mul_prod[FRAC_BITS+31:FRAC_BITS];
	assign v_ac = (|mul_prod[PROD_W-1:AC_SHIFT+32]) ? '1 : mul_prod[AC_SHIFT+31:AC_SHIFT];
	assign qcap = (|quo[DIV_W-1:40]) ? RES_CAP : {1'b0, quo[39:0]};
	assign s_new = (neg_q ^ cur_q[31]) ? (~{2'b00, qcap} + 43'd1) : {2'b00, qcap};

	// Resistance zero, clamped to a signed 32-bit value.
	always_comb begin
		if (s_q[42] && !(&s_q[42:31])) begin
			z_clamp = 32'h8000_0000;
		end else if (!s_q[42] && (|s_q[42:31])) begin
			z_clamp = CUR_CAP;
		end else begin
			z_clamp = s_q[31:0];
		end
	end

	// Final resistance with the milliohm zero removed, clamped to the output range.
	assign zuse = (op_q != OP_TWO_WIRE) ? '0 : (ohm_cap ? z_clamp : zom_q[n_q]);
	assign r_ohm = s_q - {{11{zuse[31]}}, zuse};
	assign val_ohm = r_ohm[42] ? '0 : ((|r_ohm[41:32]) ? '1 : r_ohm[31:0]);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state and unit starts.
	always_comb begin
		state_d = state_q;
		mul_start = 1'b0;
		mul_x = '0;
		mul_y = '0;
		div_start = 1'b0;
		div_dividend = '0;
		div_divisor = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = item_bad ? ST_FIN : ST_DIFF;
				end
			end
			ST_DIFF: state_d = ST_MAG;
			ST_MAG: state_d = ST_PLAN;
			ST_PLAN: begin
				if ((op_q == OP_DC_VOLT) || (op_q == OP_DC_AMP)) begin
					if (ps_q && (dm_q != '0)) begin
						div_start = 1'b1;
						div_dividend = DIV_W'({ref_q, {FRAC_BITS{1'b0}}});
						div_divisor = msat;
						state_d = ST_SDIV;
					end else begin
						state_d = ST_MST;
					end
				end else if ((op_q == OP_AC_VOLT) || (op_q == OP_AC_AMP)) begin
					state_d = ST_MST;
				end else if ((op_q == OP_TWO_WIRE) && ps_q && (ref_q != '0)) begin
					div_start = 1'b1;
					div_dividend = DIV_W'({dm_q, {FRAC_BITS{1'b0}}});
					div_divisor = ref_q;
					state_d = ST_CDIV;
				end else begin
					state_d = ST_CUR;
				end
			end
			ST_SDIV: begin
				if (div_stat.done) begin
					state_d = ST_MST;
				end
			end
			ST_MST: begin
				mul_start = 1'b1;
				mul_x = {1'b0, msat};
				mul_y = slope_q;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				if (mul_stat.done) begin
					state_d = ((op_q == OP_AC_VOLT) || (op_q == OP_AC_AMP)) ? ST_AST : ST_FIN;
				end
			end
			ST_AST: begin
				mul_start = 1'b1;
				mul_x = {1'b0, val_q};
				mul_y = K_AC;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				if (mul_stat.done) begin
					state_d = ST_FIN;
				end
			end
			ST_CDIV: begin
				if (div_stat.done) begin
					state_d = ST_CUR;
				end
			end
			ST_CUR: begin
				if (cur_q == '0) begin
					state_d = ST_FIN;
				end else begin
					mul_start = 1'b1;
					mul_x = dm_q;
					mul_y = (op_q == OP_TWO_WIRE) ? K_TWO_WIRE : K_FOUR_WIRE;
					state_d = ST_KMUL;
				end
			end
			ST_KMUL: begin
				if (mul_stat.done) begin
					div_start = 1'b1;
					div_dividend = {mul_prod[41:0], {FRAC_BITS{1'b0}}};
					div_divisor = cur_mag;
					state_d = ST_RDIV;
				end
			end
			ST_RDIV: begin
				if (div_stat.done) begin
					state_d = ST_OHM;
				end
			end
			ST_OHM: state_d = ST_FIN;
			ST_FIN: begin
				if (!res_valid_q || !result_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign load_res = (state_q == ST_FIN) && (state_d == ST_IDLE);

	// Pending requests, calibration tables and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pz_q <= 1'b0;
			ps_q <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				zdv_q[i] <= '0;
				zav_q[i] <= '0;
				zda_q[i] <= '0;
				sdv_q[i] <= SLOPE_ONE;
				sda_q[i] <= SLOPE_ONE;
			end
			for (int i = 0; i < 2; i++) begin
				zaa_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) begin
				zom_q[i] <= '0;
			end
			for (int i = 1; i < 4; i++) begin
				scur_q[i] <= SLOPE_ONE;
			end
			scur_q[0] <= SRC_CUR0;
		end else begin
			if ((state_q == ST_IDLE) && item_valid && !item_bad) begin
				pz_q <= pz_q | item.arm_zero;
				ps_q <= ps_q | item.arm_slope;
			end
			if ((state_q == ST_DIFF) && gain_cap) begin
				pz_q <= 1'b0;
				unique case (op_q)
					OP_DC_VOLT: zdv_q[n_q] <= rd_q;
					OP_AC_VOLT: zav_q[n_q] <= rd_q;
					OP_DC_AMP: zda_q[n_q] <= rd_q;
					default: zaa_q[n_q[0]] <= rd_q;
				endcase
			end
			if ((state_q == ST_PLAN) && ((op_q == OP_DC_VOLT) || (op_q == OP_DC_AMP) ||
				(op_q == OP_TWO_WIRE))) begin
				ps_q <= 1'b0;
			end
			if ((state_q == ST_SDIV) && div_stat.done) begin
				if (op_q == OP_DC_VOLT) begin
					sdv_q[n_q] <= slope_new;
				end else begin
					sda_q[n_q] <= slope_new;
				end
			end
			if ((state_q == ST_CDIV) && div_stat.done) begin
				scur_q[n_q] <= cur_new;
			end
			if ((state_q == ST_OHM) && ohm_cap) begin
				pz_q <= 1'b0;
				zom_q[n_q] <= z_clamp;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and flags of the item in progress.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					op_q <= item.op;
					n_q <= item.range_index;
					rd_q <= item.reading;
					ref_q <= item.reference;
					zc_q <= 1'b0;
					sc_q <= 1'b0;
					st_q <= 1'b0;
					de_q <= 1'b0;
					re_q <= item_bad;
					val_q <= '0;
				end
			end
			ST_DIFF: begin
				if (gain_cap) begin
					diff_q <= '0;
					zc_q <= 1'b1;
					st_q <= 1'b1;
				end else begin
					diff_q <= {rd_q[31], rd_q} - {zsel[31], zsel};
				end
				slope_q <= slope_sel;
				cur_q <= cur_sel;
			end
			ST_MAG: begin
				dm_q <= diff_q[32] ? (~diff_q + 33'd1) : diff_q;
				neg_q <= diff_q[32];
			end
			ST_PLAN: begin
				if (((op_q == OP_DC_VOLT) || (op_q == OP_DC_AMP)) && ps_q && (dm_q == '0)) begin
					de_q <= 1'b1;
				end
				if ((op_q == OP_TWO_WIRE) && ps_q && (ref_q == '0)) begin
					de_q <= 1'b1;
				end
			end
			ST_SDIV: begin
				if (div_stat.done) begin
					slope_q <= slope_new;
					sc_q <= 1'b1;
					st_q <= 1'b1;
				end
			end
			ST_MUL1: begin
				if (mul_stat.done) begin
					val_q <= v_gain;
				end
			end
			ST_MUL2: begin
				if (mul_stat.done) begin
					val_q <= v_ac;
				end
			end
			ST_CDIV: begin
				if (div_stat.done) begin
					cur_q <= cur_new;
					sc_q <= 1'b1;
					st_q <= 1'b1;
				end
			end
			ST_CUR: begin
				if (cur_q == '0) begin
					de_q <= 1'b1;
					val_q <= '1;
				end
			end
			ST_RDIV: begin
				if (div_stat.done) begin
					s_q <= s_new;
				end
			end
			ST_OHM: begin
				val_q <= val_ohm;
				if (ohm_cap) begin
					zc_q <= 1'b1;
					st_q <= 1'b1;
				end
			end
			ST_FIN: begin
				if (load_res) begin
					res_q.value <= val_q;
					res_q.zero_captured <= zc_q;
					res_q.slope_captured <= sc_q;
					res_q.store_request <= st_q;
					res_q.divide_error <= de_q;
					res_q.range_error <= re_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign item_stall = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign result = res_q;

	// A store request comes exactly with a capture.
	a_store_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.store_request ==
			(result.zero_captured || result.slope_captured)))
		else $error("store request does not match the capture flags");

	// A rejected item reports zero and touches nothing.
	a_range_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.range_error) |->
			((result.value == '0) && !result.store_request && !result.divide_error))
		else $error("range error result carries data or flags");

	// The multiplier and the divider never run at the same time.
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_stat.busy && div_stat.busy))
		else $error("multiplier and divider busy together");

	// A rejected item leaves the pending requests alone.
	a_bad_item_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_IDLE) && item_valid && item_bad) |=>
			((pz_q == $past(pz_q)) && (ps_q == $past(ps_q))))
		else $error("rejected item changed a pending request");

endmodule

`default_nettype wire

FILE: tb/meter_offset_gain_calibration_unit_tb.sv
// Testbench for the meter offset/gain calibration block: directed and random readings in all modes.
// Depends on mogc_pkg and the meter_offset_gain_calibration_unit RTL; predicts every result itself.
`default_nettype none

module meter_offset_gain_calibration_unit_tb;
	import mogc_pkg::*;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;

	meter_offset_gain_calibration_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// Calibration tables kept by the predictor.
	logic [31:0] cal_zero_dcv [3];
	logic [31:0] cal_slope_dcv [3];
	logic [31:0] cal_zero_acv [3];
	logic [31:0] cal_zero_dca [3];
	logic [31:0] cal_slope_dca [3];
	logic [31:0] cal_zero_aca [2];
	logic [31:0] cal_zero_ohm [4];
	logic [31:0] cal_src_cur [4];
	logic cal_pend_zero;
	logic cal_pend_slope;

	item_t pending_items[$];
	result_t awaited_results[$];
	int error_count;
	int send_idle_pct;
	int recv_stall_pct;
	logic send_hold;
	logic stim_done;

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] sat_top(input logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
	endfunction

	function automatic logic [63:0] abs64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	// Scaled quotient a * 2^FRAC_BITS / c, capped at 2^40.
	function automatic logic [63:0] frac_quot(input logic [63:0] a, input logic [63:0] c);
		logic [63:0] hi;
		hi = a / c;
		if (hi >= (64'd1 << (40 - FRAC_BITS)))
			return 64'd1 << 40;
		return (hi << FRAC_BITS) + (((a % c) << FRAC_BITS) / c);
	endfunction

	function automatic logic [63:0] clamp_pos(input logic signed [63:0] s);
		if (s < 0)
			return 64'd0;
		return sat_top(64'(s));
	endfunction

	task automatic reset_tables();
		for (int i = 0; i < 3; i++) begin
			cal_zero_dcv[i] = '0;
			cal_zero_acv[i] = '0;
			cal_zero_dca[i] = '0;
			cal_slope_dcv[i] = SLOPE_ONE;
			cal_slope_dca[i] = SLOPE_ONE;
		end
		for (int i = 0; i < 2; i++)
			cal_zero_aca[i] = '0;
		for (int i = 0; i < 4; i++) begin
			cal_zero_ohm[i] = '0;
			cal_src_cur[i] = SLOPE_ONE;
		end
		cal_src_cur[0] = 32'(((64'd49784 << FRAC_BITS) + 64'd50) / 64'd100);
		cal_pend_zero = 1'b0;
		cal_pend_slope = 1'b0;
	endtask

	// Shared zero capture, magnitude and optional slope capture for volt and amp modes.
	function automatic void gain_stage(input logic signed [63:0] rd, inout logic [31:0] zero_e,
			inout logic [31:0] slope_e, input logic [63:0] ref_v, input logic use_slope,
			inout result_t r, output logic [63:0] mag);
		if (cal_pend_zero) begin
			cal_pend_zero = 1'b0;
			zero_e = rd[31:0];
			r.zero_captured = 1'b1;
			r.store_request = 1'b1;
		end
		mag = sat_top(abs64(rd - 64'(signed'(zero_e))));
		if (use_slope && cal_pend_slope) begin
			cal_pend_slope = 1'b0;
			if (mag == 0) begin
				r.divide_error = 1'b1;
			end else begin
				slope_e = 32'(sat_top((ref_v << FRAC_BITS) / mag));
				r.slope_captured = 1'b1;
				r.store_request = 1'b1;
			end
		end
	endfunction

	function automatic logic signed [63:0] ohm_quot(input logic [63:0] num, input logic neg_num,
			input logic signed [63:0] cur);
		logic [63:0] q;
		q = frac_quot(num, abs64(cur));
		return (neg_num != (cur < 0)) ? -64'(signed'(q)) : 64'(signed'(q));
	endfunction

	// Computes the expected result of one reading and updates the tables.
	function automatic result_t calibrate(input item_t it);
		result_t r;
		logic signed [63:0] rd;
		logic signed [63:0] d;
		logic signed [63:0] cur;
		logic signed [63:0] s;
		logic signed [63:0] z;
		logic [63:0] ref_v;
		logic [63:0] m;
		logic [63:0] q;
		logic [63:0] dm;
		logic [31:0] dummy;
		int n;
		r = '0;
		rd = 64'(it.reading);
		ref_v = 64'(it.reference);
		n = int'(it.range_index);
		if (it.op > OP_FOUR_WIRE || (it.op != OP_FOUR_WIRE && n >= range_limit(it.op))) begin
			r.range_error = 1'b1;
			return r;
		end
		if (it.arm_zero)
			cal_pend_zero = 1'b1;
		if (it.arm_slope)
			cal_pend_slope = 1'b1;
		case (it.op)
			OP_DC_VOLT: begin
				gain_stage(rd, cal_zero_dcv[n], cal_slope_dcv[n], ref_v, 1'b1, r, m);
				r.value = 32'(sat_top((m * cal_slope_dcv[n]) >> FRAC_BITS));
			end
			OP_AC_VOLT: begin
				dummy = cal_slope_dcv[n];
				gain_stage(rd, cal_zero_acv[n], dummy, ref_v, 1'b0, r, m);
				m = sat_top((m * cal_slope_dcv[n]) >> FRAC_BITS);
				r.value = 32'(sat_top(m * 5 / 4));
			end
			OP_DC_AMP: begin
				gain_stage(rd, cal_zero_dca[n], cal_slope_dca[n], ref_v, 1'b1, r, m);
				r.value = 32'(sat_top((m * cal_slope_dca[n]) >> FRAC_BITS));
			end
			OP_AC_AMP: begin
				dummy = cal_slope_dca[n];
				gain_stage(rd, cal_zero_aca[n], dummy, ref_v, 1'b0, r, m);
				// AC amps take the gain of the next range up.
				m = sat_top((m * cal_slope_dca[(n + 1) & 3]) >> FRAC_BITS);
				r.value = 32'(sat_top(m * 5 / 4));
			end
			OP_TWO_WIRE: begin
				d = rd - 64'(signed'(cal_zero_dcv[2]));
				dm = abs64(d);
				if (cal_pend_slope) begin
					cal_pend_slope = 1'b0;
					if (ref_v == 0) begin
						r.divide_error = 1'b1;
					end else begin
						q = (dm << FRAC_BITS) / ref_v;
						if (q > 64'h7FFF_FFFF)
							q = 64'h7FFF_FFFF;
						cal_src_cur[n] = d < 0 ? 32'(-q) : 32'(q);
						r.slope_captured = 1'b1;
						r.store_request = 1'b1;
					end
				end
				cur = 64'(signed'(cal_src_cur[n]));
				if (cur == 0) begin
					r.divide_error = 1'b1;
					r.value = '1;
				end else begin
					s = ohm_quot(dm * 1000, d < 0, cur);
					if (cal_pend_zero) begin
						cal_pend_zero = 1'b0;
						z = s;
						if (z > 64'sd2147483647)
							z = 64'sd2147483647;
						if (z < -64'sd2147483648)
							z = -64'sd2147483648;
						cal_zero_ohm[n] = z[31:0];
						r.zero_captured = 1'b1;
						r.store_request = 1'b1;
					end
					r.value = 32'(clamp_pos(s - 64'(signed'(cal_zero_ohm[n]))));
				end
			end
			default: begin
				cur = 64'(signed'(cal_src_cur[0]));
				if (cur == 0) begin
					r.divide_error = 1'b1;
					r.value = '1;
				end else begin
					r.value = 32'(clamp_pos(ohm_quot(abs64(rd) * 100, rd < 0, cur)));
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h, expected %0h", what, got, want);
		error_count++;
	endtask

	// Driver: presents queued items and keeps a stalled transfer steady.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
			if (!(item_valid && item_stall)) begin
				if (item_valid)
					awaited_results.push_back(calibrate(item));
				if (pending_items.size() > 0 && !send_hold &&
						$urandom_range(99) >= send_idle_pct) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each result transfer with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result", result.value, 32'd0);
			end else begin
				want = awaited_results.pop_front();
				if (result.value !== want.value)
					report_mismatch("value", result.value, want.value);
				if (result.zero_captured !== want.zero_captured)
					report_mismatch("zero_captured", 32'(result.zero_captured),
						32'(want.zero_captured));
				if (result.slope_captured !== want.slope_captured)
					report_mismatch("slope_captured", 32'(result.slope_captured),
						32'(want.slope_captured));
				if (result.store_request !== want.store_request)
					report_mismatch("store_request", 32'(result.store_request),
						32'(want.store_request));
				if (result.divide_error !== want.divide_error)
					report_mismatch("divide_error", 32'(result.divide_error),
						32'(want.divide_error));
				if (result.range_error !== want.range_error)
					report_mismatch("range_error", 32'(result.range_error),
						32'(want.range_error));
			end
		end
	end

	function automatic item_t make_item(input logic [2:0] op, input logic [1:0] rng,
			input logic [31:0] rd, input logic [31:0] ref_v, input logic az, input logic as);
		item_t it;
		it.op = op;
		it.range_index = rng;
		it.reading = rd;
		it.reference = ref_v;
		it.arm_zero = az;
		it.arm_slope = as;
		return it;
	endfunction

	// Random reading: mostly modest values, sometimes the full range.
	function automatic logic [31:0] rand_reading();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(2000000)) - 1000000);
			default: return 32'($signed($urandom_range(200000)) - 100000);
		endcase
	endfunction

	function automatic item_t rand_item();
		item_t it;
		logic [31:0] ref_v;
		logic [2:0] op;
		op = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
		case ($urandom_range(4))
			0: ref_v = $urandom;
			1: ref_v = 32'd0;
			default: ref_v = $urandom_range(500000, 1);
		endcase
		it = make_item(op, 2'($urandom_range(3)), rand_reading(), ref_v,
			$urandom_range(5) == 0, $urandom_range(5) == 0);
		// One item in four, on average, arms a zero capture alone, with no slope capture.
		if ($urandom_range(3) == 0) begin
			it.arm_zero = 1'b1;
			it.arm_slope = 1'b0;
		end
		return it;
	endfunction

	task automatic wait_drained();
		while (pending_items.size() > 0 || item_valid || awaited_results.size() > 0)
			@(posedge clk);
	endtask

	// Stimulus: directed corners, then random items in several idling phases.
	initial begin
		error_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_hold = 1'b0;
		stim_done = 1'b0;
		reset_tables();
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Invalid modes and ranges, with arm bits that must be ignored.
		pending_items.push_back(make_item(3'd6, 2'd0, 32'd5, 32'd5, 1'b1, 1'b1));
		pending_items.push_back(make_item(3'd7, 2'd3, 32'hFFFF_FFFF, '1, 1'b1, 1'b1));
		pending_items.push_back(make_item(OP_DC_VOLT, 2'd3, 32'd1, 32'd1, 1'b1, 1'b0));
		pending_items.push_back(make_item(OP_AC_AMP, 2'd2, 32'd1, 32'd1, 1'b0, 1'b1));
		// Extreme readings with reset tables.
		pending_items.push_back(make_item(OP_DC_VOLT, 2'd0, 32'h8000_0000, '0, 1'b0, 1'b0));
		pending_items.push_back(make_item(OP_DC_AMP, 2'd2, 32'h7FFF_FFFF, '1, 1'b0, 1'b0));
		pending_items.push_back(make_item(OP_AC_VOLT, 2'd1, 32'h8000_0000, '0, 1'b0, 1'b0));
		pending_items.push_back(make_item(OP_AC_AMP, 2'd1, 32'h7FFF_FFFF, '0, 1'b0, 1'b0));
		pending_items.push_back(make_item(OP_FOUR_WIRE, 2'd3, 32'h7FFF_FFFF, '0, 1'b1, 1'b1));
		pending_items.push_back(make_item(OP_FOUR_WIRE, 2'd0, 32'h8000_0000, '0, 1'b0, 1'b0));
		// Zero capture then slope capture; a zero magnitude slope is a divide error.
		pending_items.push_back(make_item(OP_DC_VOLT, 2'd1, 32'd1000, 32'd0, 1'b1, 1'b0));
		pending_items.push_back(make_item(OP_DC_VOLT, 2'd1, 32'd1000, 32'd50, 1'b0, 1'b1));
		pending_items.push_back(make_item(OP_DC_VOLT, 2'd1, 32'd3000, '1, 1'b0, 1'b1));
		pending_items.push_back(make_item(OP_DC_AMP, 2'd0, 32'd7, 32'd0, 1'b0, 1'b1));
		// AC mode leaves the slope request armed for the next DC item.
		pending_items.push_back(make_item(OP_AC_VOLT, 2'd2, -32'd500, 32'd9, 1'b1, 1'b1));
		pending_items.push_back(make_item(OP_DC_AMP, 2'd1, 32'd400, 32'd800, 1'b0, 1'b0));
		// Two-wire: zero reference, then a current capture of zero makes the current zero.
		pending_items.push_back(make_item(OP_TWO_WIRE, 2'd1, 32'd100, 32'd0, 1'b0, 1'b1));
		pending_items.push_back(make_item(OP_TWO_WIRE, 2'd1, 32'd0, 32'd10, 1'b0, 1'b1));
		pending_items.push_back(make_item(OP_TWO_WIRE, 2'd1, 32'd55, 32'd10, 1'b1, 1'b0));
		pending_items.push_back(make_item(OP_TWO_WIRE, 2'd1, 32'd77, 32'd10, 1'b0, 1'b1));
		pending_items.push_back(make_item(OP_TWO_WIRE, 2'd2, 32'h7FFF_FFFF, 32'd1, 1'b0, 1'b1));
		pending_items.push_back(make_item(OP_TWO_WIRE, 2'd3, -32'd9000, 32'd3, 1'b1, 1'b1));
		pending_items.push_back(make_item(OP_TWO_WIRE, 2'd0, 32'd20000, 32'd0, 1'b0, 1'b0));
		wait_drained();

		// Random phases with different idling mixes.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 48; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 48; end
				3: begin send_idle_pct = 18; recv_stall_pct = 18; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int i = 0; i < 260; i++)
				pending_items.push_back(rand_item());
			if (ph == 2) begin
				// Hold the sender until everything outstanding has come back.
				while (pending_items.size() > 130)
					@(posedge clk);
				send_hold = 1'b1;
				while (item_valid || awaited_results.size() > 0)
					@(posedge clk);
				send_hold = 1'b0;
			end
			wait_drained();
		end
		repeat (200) @(posedge clk);
		if (error_count == 0 && awaited_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog.
	initial begin
		#20000000;
		$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
rtl/mogc_pkg.sv
rtl/mogc_mul.sv
rtl/mogc_div.sv
rtl/meter_offset_gain_calibration_unit.sv
tb/meter_offset_gain_calibration_unit_tb.sv
